FILE: rtl/cbfd_pkg.sv
// Shared types, constants and the frame decode function of the CAN button frame decoder.
// Used by the decoder top level and its port checker; depends on nothing else.
package cbfd_pkg;

	typedef logic [12:0] code_t;

	localparam code_t IDLE_CODE = 13'd4444;
	localparam code_t BTN_50    = 13'd50;
	localparam code_t BTN_100   = 13'd100;
	localparam code_t BTN_150   = 13'd150;
	localparam code_t BTN_200   = 13'd200;
	localparam code_t BTN_250   = 13'd250;
	localparam code_t BTN_300   = 13'd300;
	localparam code_t BTN_350   = 13'd350;
	localparam code_t BTN_400   = 13'd400;

	// Vehicle layouts.
	localparam logic [1:0] VSEL_A = 2'd1;
	localparam logic [1:0] VSEL_B = 2'd2;

	localparam logic [3:0] LEN_A = 4'd4;
	localparam logic [3:0] LEN_B = 4'd2;

	// Configuration register indexes.
	localparam logic REG_VEHICLE_SELECT  = 1'b0;
	localparam logic REG_BUTTON_FRAME_ID = 1'b1;

	// Layout A data codes.
	localparam logic [7:0] A_RELEASE  = 8'h00;
	localparam logic [7:0] A_B50      = 8'h15;
	localparam logic [7:0] A_B100     = 8'h16;
	localparam logic [7:0] A_B150     = 8'h13;
	localparam logic [7:0] A_ENCODER  = 8'h12;
	localparam logic [7:0] A_ENC_UP   = 8'h01;
	localparam logic [7:0] A_ENC_DOWN = 8'h0F;
	localparam logic [7:0] A_B300     = 8'h14;

	// Layout B data codes.
	localparam logic [7:0] B_GROUP1   = 8'h39;
	localparam logic [7:0] B_GROUP2   = 8'h3A;
	localparam logic [7:0] B_GROUP3   = 8'h3C;
	localparam logic [7:0] B_GROUP4   = 8'h3B;
	localparam logic [7:0] B_RELEASE  = 8'h00;
	localparam logic [7:0] B_B50      = 8'h0B;
	localparam logic [7:0] B_B100     = 8'h1C;
	localparam logic [7:0] B_B150     = 8'h0C;
	localparam logic [7:0] B_ENC_UP   = 8'h08;
	localparam logic [7:0] B_ENC_DOWN = 8'h06;
	localparam logic [7:0] B_B300     = 8'h2A;
	localparam logic [7:0] B_B350     = 8'h07;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_RELEASE,
		ACT_PRESS,
		ACT_ENCODER
	} act_t;

	typedef struct packed {
		act_t  act;
		code_t code;
	} dec_t;

	// Classifies the data bytes of a frame that already matched identifier and length.
	function automatic dec_t decode_frame(input logic [1:0] vsel, input logic [7:0] b0,
			input logic [7:0] b1, input logic [7:0] b2);
		dec_t d;
		d.act  = ACT_NONE;
		d.code = IDLE_CODE;
		if (vsel == VSEL_A) begin
			if (b0 == A_RELEASE) begin
				d.act = ACT_RELEASE;
			end else if (b0 == A_B50) begin
				d.act = ACT_PRESS; d.code = BTN_50;
			end else if (b0 == A_B100) begin
				d.act = ACT_PRESS; d.code = BTN_100;
			end else if (b0 == A_B150) begin
				d.act = ACT_PRESS; d.code = BTN_150;
			end else if (b0 == A_ENCODER && b2 == A_ENC_UP) begin
				d.act = ACT_ENCODER; d.code = BTN_200;
			end else if (b0 == A_ENCODER && b2 == A_ENC_DOWN) begin
				d.act = ACT_ENCODER; d.code = BTN_250;
			end else if (b0 == A_B300) begin
				d.act = ACT_PRESS; d.code = BTN_300;
			end
		end else if (vsel == VSEL_B) begin
			if (b0 == B_GROUP1 && b1 == B_RELEASE) begin
				d.act = ACT_RELEASE;
			end else if (b0 == B_GROUP1 && b1 == B_B50) begin
				d.act = ACT_PRESS; d.code = BTN_50;
			end else if (b0 == B_GROUP2 && b1 == B_B100) begin
				d.act = ACT_PRESS; d.code = BTN_100;
			end else if (b0 == B_GROUP1 && b1 == B_B150) begin
				d.act = ACT_PRESS; d.code = BTN_150;
			end else if (b0 == B_GROUP1 && b1 == B_ENC_UP) begin
				d.act = ACT_ENCODER; d.code = BTN_200;
			end else if (b0 == B_GROUP1 && b1 == B_ENC_DOWN) begin
				d.act = ACT_ENCODER; d.code = BTN_250;
			end else if (b0 == B_GROUP3 && b1 == B_B300) begin
				d.act = ACT_PRESS; d.code = BTN_300;
			end else if (b0 == B_GROUP1 && b1 == B_B350) begin
				d.act = ACT_PRESS; d.code = BTN_350;
			end else if (b0 == B_GROUP4 && b1 == B_RELEASE) begin
				d.act = ACT_PRESS; d.code = BTN_400;
			end
		end
		return d;
	endfunction

endpackage

FILE: rtl/can_button_frame_decoder.sv
// Top level of the CAN steering-wheel button frame decoder.
// Depends on cbfd_pkg for codes, types and the data byte decode function.
//
// Channel  Direction  Handshake                 Payload
// s_       in         s_tvalid / s_tready       s_tdata frame fields, s_tuser is_standard
// m_       out        m_tvalid / m_tready       m_tdata button_code, pressed; m_tlast last
// cfg_     in         cfg_we (no wait)          cfg_index, cfg_wdata
//
// A frame is taken into the input register and decoded there against the held
// button; its zero to three events move into an event register at once when that register
// is empty or hands over its final event in the same cycle.
// The output then delivers one event per cycle while m_tready is high.
// Reset clears the held button to 0, both registers to empty and the configuration to 0.
// While m_tready is low the current event holds and one more frame may wait decoded.
module can_button_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// frame_length[3:0], frame_id[32:4], byte0[40:33], byte1[48:41], byte2[56:49], zeros
	input  logic [63:0] s_tdata,
	// is_standard[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// button_code[12:0], pressed[13], zeros
	output logic [15:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_wdata
);
	import cbfd_pkg::*;

	logic [1:0]  vehicle_select_q;
	logic [10:0] button_frame_id_q;
	code_t       held_q;

	// Input register.
	logic        valid_s1;
	logic        std_s1;
	logic [3:0]  len_s1;
	logic [28:0] id_s1;
	logic [7:0]  b0_s1;
	logic [7:0]  b1_s1;
	logic [7:0]  b2_s1;

	// Event register: up to three events of one frame.
	code_t       ev_code_q [3];
	logic        ev_pr_q   [3];
	logic [1:0]  ev_cnt_q;
	logic [1:0]  ev_idx_q;

	dec_t        dec;
	logic        match;
	code_t       nx_code   [3];
	logic        nx_pr     [3];
	logic [1:0]  nx_cnt;
	code_t       nx_held;
	logic        out_fire;
	logic        finishing;
	logic        advance;

	always_comb begin
		match = valid_s1 && std_s1 && (id_s1 == {18'd0, button_frame_id_q}) &&
			((vehicle_select_q == VSEL_A && len_s1 == LEN_A) ||
			 (vehicle_select_q == VSEL_B && len_s1 == LEN_B));
		dec = decode_frame(vehicle_select_q, b0_s1, b1_s1, b2_s1);
		nx_cnt  = 2'd0;
		nx_held = held_q;
		nx_code[0] = dec.code;  nx_pr[0] = 1'b1;
		nx_code[1] = dec.code;  nx_pr[1] = 1'b0;
		nx_code[2] = IDLE_CODE; nx_pr[2] = 1'b0;
		if (match) begin
			case (dec.act)
				ACT_RELEASE: begin
					// Release only when a button other than idle is held.
					if (held_q != IDLE_CODE) begin
						nx_cnt     = 2'd2;
						nx_code[0] = held_q;
						nx_pr[0]   = 1'b0;
						nx_code[1] = IDLE_CODE;
						nx_held    = IDLE_CODE;
					end
				end
				ACT_PRESS: begin
					nx_cnt  = 2'd1;
					nx_held = dec.code;
				end
				ACT_ENCODER: begin
					nx_cnt  = 2'd3;
					nx_held = IDLE_CODE;
				end
				default: begin
					nx_cnt = 2'd0;
				end
			endcase
		end
	end

	assign m_tvalid  = (ev_cnt_q != 2'd0);
	assign m_tlast   = (ev_idx_q == ev_cnt_q - 2'd1);
	assign m_tdata   = {2'b00, ev_pr_q[ev_idx_q], ev_code_q[ev_idx_q]};
	assign out_fire  = m_tvalid && m_tready;
	assign finishing = out_fire && m_tlast;
	assign advance   = valid_s1 && (!m_tvalid || finishing);
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vehicle_select_q  <= 2'd0;
			button_frame_id_q <= 11'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VEHICLE_SELECT:  vehicle_select_q  <= cfg_wdata[1:0];
				REG_BUTTON_FRAME_ID: button_frame_id_q <= cfg_wdata;
				default:             vehicle_select_q  <= vehicle_select_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			std_s1 <= s_tuser[0];
			len_s1 <= s_tdata[3:0];
			id_s1  <= s_tdata[32:4];
			b0_s1  <= s_tdata[40:33];
			b1_s1  <= s_tdata[48:41];
			b2_s1  <= s_tdata[56:49];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			ev_cnt_q <= 2'd0;
			ev_idx_q <= 2'd0;
		end else if (advance) begin
			held_q   <= nx_held;
			ev_cnt_q <= nx_cnt;
			ev_idx_q <= 2'd0;
		end else if (finishing) begin
			ev_cnt_q <= 2'd0;
			ev_idx_q <= 2'd0;
		end else if (out_fire) begin
			ev_idx_q <= ev_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				ev_code_q[i] <= nx_code[i];
				ev_pr_q[i]   <= nx_pr[i];
			end
		end
	end

endmodule

FILE: rtl/cbfd_checker.sv
// Port-level checker for the CAN button frame decoder, bound to the top level.
// Depends on cbfd_pkg for the idle button code.
module cbfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);
	import cbfd_pkg::*;

	logic out_fire;
	assign out_fire = m_tvalid && m_tready;

	// A stalled event holds its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled event changed");

	// The events of one frame follow each other without a gap.
	a_run_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !m_tlast |=> m_tvalid)
		else $error("gap inside an event run");

	// A press that is not last belongs to an encoder and is followed by its release.
	a_enc_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !m_tlast && m_tdata[13] |=>
			!m_tdata[13] && !m_tlast && m_tdata[12:0] == $past(m_tdata[12:0]))
		else $error("encoder press not followed by its release");

	// A release that is not last is followed by the closing idle release.
	a_idle_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !m_tlast && !m_tdata[13] |=> m_tdata[12:0] == IDLE_CODE && m_tlast)
		else $error("release not followed by idle");

	// The idle code only ever closes a run, as a release.
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12:0] == IDLE_CODE |-> m_tlast && !m_tdata[13])
		else $error("idle code not a final release");

endmodule

bind can_button_frame_decoder cbfd_checker u_cbfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
